@@ design/crt_pkg.sv @@
// Shared types and constants for the cacheability range table.
package crt_pkg;

	localparam int MaxRanges = 32;
	localparam int IdxW = $clog2(MaxRanges);
	localparam int CntW = $clog2(MaxRanges + 1);

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_IGNORED = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [63:0] address;
		logic [63:0] range_end;
		logic        write_back;
		logic        write_through;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] region_end;
		logic        is_write_back;
		logic        is_write_through;
	} rsp_t;

	// One entry of the range memory.
	typedef struct packed {
		logic [63:0] base;
		logic [63:0] length;
		logic        wt;
	} entry_t;

endpackage

@@ design/crt_mem.sv @@
// Range entry memory: one write port, one registered read port.
module crt_mem (
	input  logic                 clk,
	input  logic                 we,
	input  logic [crt_pkg::IdxW-1:0] waddr,
	input  crt_pkg::entry_t      wdata,
	input  logic [crt_pkg::IdxW-1:0] raddr,
	output crt_pkg::entry_t      rdata
);
	import crt_pkg::*;

	entry_t mem [MaxRanges];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/cacheability_range_table.sv @@
// Top level of the cacheability range table: sequencer around one entry memory.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/req_ready | crt_pkg::req_t
//  rsp     | out | rsp_valid/rsp_ready | crt_pkg::rsp_t
//
// A scan reads each entry through the single memory read port in a read state and
// a wait state (ST_SCAN, ST_SWAIT), and an insert then shifts entries one a cycle
// (up to make room, down after a double merge).
// Reset clears the entry count; the entries themselves start undefined.
// The block takes no request until the response has been taken.
module cacheability_range_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  crt_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output crt_pkg::rsp_t  rsp
);
	import crt_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SCAN  = 9'b000000010,
		ST_SWAIT = 9'b000000100,
		ST_ABOVE = 9'b000001000,
		ST_AWAIT = 9'b000010000,
		ST_DECIDE= 9'b000100000,
		ST_SHUP  = 9'b001000000,
		ST_SHDN  = 9'b010000000,
		ST_RESP  = 9'b100000000
	} state_t;

	state_t state_q;
	req_t   req_q;
	rsp_t   rsp_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] pos_q;   // entries with base <= key
	logic [CntW-1:0] ptr_q;
	entry_t below_q, above_q;
	logic [63:0] size_q;

	logic we;
	logic [IdxW-1:0] waddr, raddr;
	entry_t wdata, rdata;

	crt_mem u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic has_below, has_above, join_a, join_b;
	logic [63:0] below_end;
	always_comb begin
		has_below = pos_q != '0;
		has_above = pos_q < count_q;
		below_end = below_q.base + below_q.length;
		join_a = has_above && above_q.wt == req_q.write_through
			&& above_q.base == req_q.range_end;
		join_b = has_below && below_q.wt == req_q.write_through
			&& below_end == req_q.address;
	end

	// Memory port control.
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q[IdxW-1:0];
		wdata = rdata;
		raddr = ptr_q[IdxW-1:0];
		case (state_q)
			ST_ABOVE: raddr = pos_q[IdxW-1:0];
			ST_DECIDE: begin
				raddr = count_q[IdxW-1:0] - 1'b1;
				if (join_a && join_b) begin
					we = 1'b1;
					waddr = pos_q[IdxW-1:0] - 1'b1;
					wdata = '{below_q.base, below_q.length + size_q + above_q.length,
						below_q.wt};
					// fetch the first entry to move down
					raddr = pos_q[IdxW-1:0] + 1'b1;
				end else if (join_a) begin
					we = 1'b1;
					waddr = pos_q[IdxW-1:0];
					wdata = '{req_q.address, above_q.length + size_q, above_q.wt};
				end else if (join_b) begin
					we = 1'b1;
					waddr = pos_q[IdxW-1:0] - 1'b1;
					wdata = '{below_q.base, below_q.length + size_q, below_q.wt};
				end else if (count_q != CntW'(MaxRanges) && count_q == pos_q) begin
					we = 1'b1;
					waddr = pos_q[IdxW-1:0];
					wdata = '{req_q.address, size_q, req_q.write_through};
				end
			end
			ST_SHUP: begin
				// rdata holds entry ptr-1; move it to ptr
				we = 1'b1;
				waddr = ptr_q[IdxW-1:0];
				if (ptr_q == pos_q) begin
					wdata = '{req_q.address, size_q, req_q.write_through};
				end
				raddr = ptr_q[IdxW-1:0] - 2'd2;
			end
			ST_SHDN: begin
				// rdata holds entry ptr+1; move it to ptr
				we = (ptr_q + 1'b1) < count_q;
				waddr = ptr_q[IdxW-1:0];
				raddr = ptr_q[IdxW-1:0] + 2'd2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q   <= '0;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q  <= req;
						size_q <= req.range_end - req.address;
						pos_q  <= '0;
						ptr_q  <= '0;
						if (req.req_type == REQ_INSERT && (req.range_end == req.address
							|| (req.write_back && req.write_through))) begin
							rsp_q   <= '{STATUS_IGNORED, 64'd0, 1'b0, 1'b0};
							state_q <= ST_RESP;
						end else if (count_q == '0) begin
							state_q <= ST_ABOVE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: state_q <= ST_SWAIT; // read of entry ptr in flight
				ST_SWAIT: begin
					if (rdata.base <= req_q.address) begin
						below_q <= rdata;
						pos_q   <= ptr_q + 1'b1;
						if (ptr_q + 1'b1 == count_q) begin
							state_q <= ST_ABOVE;
						end else begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end else begin
						state_q <= ST_ABOVE;
					end
				end
				ST_ABOVE: state_q <= ST_AWAIT;
				ST_AWAIT: begin
					above_q <= rdata;
					if (req_q.req_type == REQ_LOOKUP) begin
						if (pos_q != '0 && req_q.address < below_end) begin
							rsp_q <= '{STATUS_DONE, below_end, 1'b0, below_q.wt};
						end else begin
							rsp_q <= '{STATUS_DONE,
								(pos_q < count_q) ? rdata.base : '1, 1'b1, 1'b1};
						end
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					rsp_q <= '{STATUS_DONE, 64'd0, 1'b0, 1'b0};
					if (join_a && join_b) begin
						ptr_q   <= pos_q;
						state_q <= ST_SHDN;
					end else if (join_a || join_b) begin
						state_q <= ST_RESP;
					end else if (count_q == CntW'(MaxRanges)) begin
						rsp_q   <= '{STATUS_FULL, 64'd0, 1'b0, 1'b0};
						state_q <= ST_RESP;
					end else begin
						count_q <= count_q + 1'b1;
						if (count_q == pos_q) begin
							state_q <= ST_RESP;
						end else begin
							ptr_q   <= count_q;
							state_q <= ST_SHUP;
						end
					end
				end
				ST_SHUP: begin
					// Walk down from the new top, ending with the new entry at pos.
					if (ptr_q == pos_q) begin
						state_q <= ST_RESP;
					end else begin
						ptr_q <= ptr_q - 1'b1;
					end
				end
				ST_SHDN: begin
					// Copy entries down from pos+1 up to the old top.
					if ((ptr_q + 1'b1) >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= ST_RESP;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_RESP: if (rsp_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = state_q == ST_RESP;
	assign rsp = rsp_q;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("ready while response pending");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxRanges)) else $error("entry count overflow");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != 2'd3) else $error("bad status");
	a_lookup_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && req_q.req_type == REQ_LOOKUP |-> rsp.status == STATUS_DONE)
		else $error("lookup with non-done status");

endmodule

@@ tb/cacheability_range_table_tb.sv @@
// Self-checking testbench for the cacheability range table.
`timescale 1ns / 100ps

module cacheability_range_table_tb;
	import crt_pkg::*;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	cacheability_range_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the range table
	logic [63:0] tbl_base [MaxRanges];
	logic [63:0] tbl_len [MaxRanges];
	logic        tbl_wt [MaxRanges];
	int          tbl_cnt;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   errors = 0;
	bit   stim_done = 0;
	bit   hold_off = 0;

	// transactions taken at the last rising edge
	logic req_acc = 1'b0;
	logic rsp_acc = 1'b0;

	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic int count_le(input logic [63:0] key);
		int i;
		i = 0;
		while (i < tbl_cnt && tbl_base[i] <= key) i++;
		return i;
	endfunction

	function automatic rsp_t predict_table(input req_t r);
		rsp_t o;
		logic [63:0] sz;
		int p;
		bit ja, jb;
		o = '0;
		p = count_le(r.address);
		if (r.req_type == REQ_LOOKUP) begin
			if (p > 0 && r.address < tbl_base[p-1] + tbl_len[p-1]) begin
				o.region_end = tbl_base[p-1] + tbl_len[p-1];
				o.is_write_through = tbl_wt[p-1];
			end else begin
				o.region_end = (p < tbl_cnt) ? tbl_base[p] : '1;
				o.is_write_back = 1'b1;
				o.is_write_through = 1'b1;
			end
			return o;
		end
		sz = r.range_end - r.address;
		if (sz == 0 || (r.write_back && r.write_through)) begin
			o.status = STATUS_IGNORED;
			return o;
		end
		ja = p < tbl_cnt && tbl_wt[p] == r.write_through && tbl_base[p] == r.address + sz;
		jb = p > 0 && tbl_wt[p-1] == r.write_through &&
			tbl_base[p-1] + tbl_len[p-1] == r.address;
		o.status = STATUS_DONE;
		if (ja && jb) begin
			tbl_len[p-1] += sz + tbl_len[p];
			for (int i = p; i + 1 < tbl_cnt; i++) begin
				tbl_base[i] = tbl_base[i+1];
				tbl_len[i] = tbl_len[i+1];
				tbl_wt[i] = tbl_wt[i+1];
			end
			tbl_cnt--;
		end else if (ja) begin
			tbl_base[p] = r.address;
			tbl_len[p] += sz;
		end else if (jb) begin
			tbl_len[p-1] += sz;
		end else if (tbl_cnt >= MaxRanges) begin
			o.status = STATUS_FULL;
		end else begin
			for (int i = tbl_cnt; i > p; i--) begin
				tbl_base[i] = tbl_base[i-1];
				tbl_len[i] = tbl_len[i-1];
				tbl_wt[i] = tbl_wt[i-1];
			end
			tbl_base[p] = r.address;
			tbl_len[p] = sz;
			tbl_wt[p] = r.write_through;
			tbl_cnt++;
		end
		return o;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t make_req(input logic rt, input logic [63:0] a,
		input logic [63:0] e, input logic wb, input logic wt);
		req_t r;
		r.req_type = rt;
		r.address = a;
		r.range_end = e;
		r.write_back = wb;
		r.write_through = wt;
		return r;
	endfunction

	// address near a small set of boundaries so ranges touch often
	function automatic logic [63:0] near_addr();
		case ($urandom_range(0, 5))
			0: return rand64();
			1: return 64'hFFFF_FFFF_FFFF_FF00 + $urandom_range(0, 255);
			default: return 64'(16 * $urandom_range(0, 63));
		endcase
	endfunction

	always @(posedge clk) begin
		req_acc <= arst_n && req_valid && req_ready;
		rsp_acc <= arst_n && rsp_valid && rsp_ready;
	end

	// driver: one transaction at a time from the pending queue
	int gap = 0;
	always @(negedge clk) begin
		if (req_valid && !req_acc) begin
			// hold
		end else if (gap > 0) begin
			req_valid <= 1'b0;
			gap <= gap - 1;
		end else if (arst_n && !hold_off && pending_reqs.size() > 0) begin
			req <= pending_reqs.pop_front();
			req_valid <= 1'b1;
			gap <= $urandom_range(0, 19) * ($urandom_range(0, 3) != 0);
		end else begin
			req_valid <= 1'b0;
		end
	end

	int stall = 0;
	always @(negedge clk) begin
		if (rsp_acc) begin
			stall = $urandom_range(0, 19) * ($urandom_range(0, 3) != 0);
		end
		if (stall > 0) begin
			rsp_ready <= 1'b0;
			stall--;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// monitor: predict on accepted requests, check accepted responses
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready)
			expected_rsps.push_back(predict_table(req));
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				report("response with none expected");
			end else begin
				rsp_t e;
				e = expected_rsps.pop_front();
				if (rsp.status !== e.status)
					report($sformatf("status %0d exp %0d", rsp.status, e.status));
				if (rsp.region_end !== e.region_end)
					report($sformatf("region_end %h exp %h", rsp.region_end, e.region_end));
				if (rsp.is_write_back !== e.is_write_back)
					report("is_write_back");
				if (rsp.is_write_through !== e.is_write_through)
					report("is_write_through");
			end
		end
	end

	initial begin
		logic [63:0] a;
		tbl_cnt = 0;
		// directed: extremes, ignored cases, merges, wrap, lookups
		pending_reqs.push_back(make_req(REQ_LOOKUP, 64'h0, '1, 1, 1));
		pending_reqs.push_back(make_req(REQ_LOOKUP, '1, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h100, 64'h100, 0, 0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h100, 64'h200, 1, 1));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h100, 64'h200, 1, 0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h300, 64'h400, 0, 0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h200, 64'h300, 0, 0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h400, 64'h500, 0, 1));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h80, 64'h100, 0, 0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h500, 64'h600, 0, 1));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h0, 64'h40, 0, 1));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h40, 64'h80, 0, 0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10, 0, 1));
		pending_reqs.push_back(make_req(REQ_INSERT, '1, 64'h0, 0, 0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h300, 64'h380, 0, 1));
		pending_reqs.push_back(make_req(REQ_LOOKUP, 64'h0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_LOOKUP, 64'h250, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_LOOKUP, 64'h450, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_LOOKUP, 64'h700, '1, 1, 1));
		pending_reqs.push_back(make_req(REQ_LOOKUP, '1, 0, 0, 0));
		// fill the table to overflow with disjoint ranges
		for (int i = 0; i < 36; i++)
			pending_reqs.push_back(make_req(REQ_INSERT, 64'h1_0000 + 64'(i) * 64'h100,
				64'h1_0000 + 64'(i) * 64'h100 + 64'h80, 0, 1'(i)));
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
		hold_off = 1;
		repeat (20) @(posedge clk);
		hold_off = 0;
		// random: mostly small inserts, plus lookups, near shared boundaries
		for (int i = 0; i < 1500; i++) begin
			a = near_addr();
			if ($urandom_range(0, 2) == 0)
				pending_reqs.push_back(make_req(REQ_LOOKUP, a, rand64(),
					1'($urandom), 1'($urandom)));
			else
				pending_reqs.push_back(make_req(REQ_INSERT, a,
					($urandom_range(0, 9) == 0) ? rand64() : a + 16 * $urandom_range(0, 3),
					($urandom_range(0, 3) == 0), 1'($urandom)));
			if (i % 300 == 299) begin
				wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
				hold_off = 1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
				hold_off = 0;
			end
		end
		wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
